// ----- hdl/assert_macros.svh -----
// Assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr must hold at every clock edge outside reset
`define LIS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: always");

// cond in a cycle implies expr in the same cycle
`define LIS_ASSERT_IMPLY(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: implication");

// cond in a cycle implies expr in the next cycle
`define LIS_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next cycle");

`else

`define LIS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define LIS_ASSERT_IMPLY(lbl, clk, rst, cond, expr)
`define LIS_ASSERT_NEXT(lbl, clk, rst, cond, expr)

`endif

`endif

// ----- hdl/lis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lis_pkg;

   // tail table depth
   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   // running length counter, must hold MAX_LEN itself
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   // transaction field widths
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 11;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [LEN_W-1:0]          length_type;

endpackage

`default_nettype wire

// ----- hdl/lis_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lis_req_if;
   logic                valid;
   logic                ready;
   lis_pkg::value_type  value;
   logic                last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_rsp_if;
   logic                valid;
   logic                ready;
   lis_pkg::length_type length;
   logic                final_res;
   logic                overflow;

   modport source (output valid, output length, output final_res, output overflow,
                   input ready);
   modport sink   (input valid, input length, input final_res, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/lis_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ----- hdl/strict_lis_length.sv -----
// strict_lis_length: running length of the longest strictly increasing
// subsequence of a stream of signed 32-bit values.
// req_ch (sink): one transaction per value; last closes the sequence.
// rsp_ch (source): one transaction per request carrying the running
//   length, a copy of last (final_res) and the sticky overflow flag.
// Smallest tail per length sits in a 1024 x 32 RAM; the top tail is also
// held in a register, so appends, repeats of the top and the first value
// need no RAM read and go from idle straight to the done state. A value
// below the top tail runs a binary search through the single RAM read
// port; each halving step issues the read in the search state and
// compares in the wait state. The search state then replaces the tail
// and the done state loads the output register.
// req_ch.ready is high only in idle. The output register lets a new request
// in while an earlier result waits; if rsp stalls, a finished request waits
// in the done state until the register frees, and req_ch.ready stays low.
// Reset (synchronous, active high) clears length, overflow and handshake
// state; the tail RAM is not cleared, only tails of this sequence are read.
// A dropped append (table full) sets overflow until the result of the
// last value; length and overflow then clear.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module strict_lis_length (
   input wire logic   clock,
   input wire logic   reset,
   lis_req_if.sink    req_ch,
   lis_rsp_if.source  rsp_ch
);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;  // issue read of mid, or finish
   localparam logic [1:0] ST_WAIT   = 2'd2;  // compare against read data
   localparam logic [1:0] ST_DONE   = 2'd3;  // hand result to output reg

   logic [1:0] state_ff, state_in;

   logic [lis_pkg::CNT_W-1:0]  len_ff, len_in;
   logic                       ovf_ff, ovf_in;
   lis_pkg::value_type         top_ff, top_in;     // copy of tails[len-1]
   lis_pkg::value_type         key_ff, key_in;
   logic                       last_ff, last_in;
   logic [lis_pkg::ADDR_W-1:0] lo_ff, lo_in;
   logic [lis_pkg::ADDR_W-1:0] hi_ff, hi_in;
   logic [lis_pkg::ADDR_W-1:0] mid_ff, mid_in;
   logic [lis_pkg::ADDR_W-1:0] mid;
   logic [lis_pkg::ADDR_W-1:0] top_idx;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   lis_pkg::length_type rsp_len_ff, rsp_len_in;
   logic                rsp_final_ff, rsp_final_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   // tail RAM port
   logic                          ram_we;
   logic [lis_pkg::ADDR_W-1:0]    ram_waddr;
   lis_pkg::value_type            ram_wdata;
   logic [lis_pkg::VALUE_W-1:0]   ram_rdata;
   lis_pkg::value_type            tail_rd;

   logic req_fire;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign top_idx = lis_pkg::ADDR_W'(len_ff - lis_pkg::CNT_W'(1));
   assign tail_rd = $signed(ram_rdata);

   lis_ram #(
      .WIDTH (lis_pkg::VALUE_W),
      .DEPTH (lis_pkg::MAX_LEN)
   ) u_tails (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (mid),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      top_in       = top_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ram_we       = 1'b0;
      ram_waddr    = lo_ff;
      ram_wdata    = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in   = req_ch.value;
               last_in  = req_ch.last;
               state_in = ST_DONE;
               if (len_ff == '0) begin
                  // empty table: first value always starts length 1
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = req_ch.value;
                  top_in    = req_ch.value;
                  len_in    = lis_pkg::CNT_W'(1);
               end else if (req_ch.value > top_ff) begin
                  if (len_ff < lis_pkg::CNT_W'(lis_pkg::MAX_LEN)) begin
                     ram_we    = 1'b1;
                     ram_waddr = lis_pkg::ADDR_W'(len_ff);
                     ram_wdata = req_ch.value;
                     top_in    = req_ch.value;
                     len_in    = len_ff + lis_pkg::CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;   // table full, append dropped
                  end
               end else if (req_ch.value != top_ff) begin
                  lo_in    = '0;
                  hi_in    = top_idx;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = ST_WAIT;
            end else begin
               // first tail not below key found: replace it
               ram_we    = 1'b1;
               ram_waddr = lo_ff;
               ram_wdata = key_ff;
               if (lo_ff == top_idx) begin
                  top_in = key_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_WAIT: begin
            if (key_ff <= tail_rd) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + lis_pkg::ADDR_W'(1);
            end
            state_in = ST_SEARCH;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = lis_pkg::LEN_W'(len_ff);
               rsp_final_in = last_ff;
               rsp_ovf_in   = ovf_ff;
               if (last_ff) begin
                  len_in = '0;
                  ovf_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      key_ff       <= key_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.length    = rsp_len_ff;
   assign rsp_ch.final_res = rsp_final_ff;
   assign rsp_ch.overflow  = rsp_ovf_ff;

   // length never passes the table depth
   `LIS_ASSERT_ALWAYS(a_len_bound, clock, reset, len_ff <= lis_pkg::CNT_W'(lis_pkg::MAX_LEN))
   // search window stays ordered and inside the valid tails
   `LIS_ASSERT_IMPLY(a_search_win, clock, reset, state_ff == ST_SEARCH, lo_ff <= hi_ff && hi_ff <= top_idx)
   // probe point lies strictly below the upper bound
   `LIS_ASSERT_IMPLY(a_mid_range, clock, reset, state_ff == ST_WAIT, mid_ff >= lo_ff && mid_ff < hi_ff)
   // an accepted request always leaves idle
   `LIS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, state_ff != ST_IDLE)
   // a search only runs on a non-empty table
   `LIS_ASSERT_IMPLY(a_search_nonempty, clock, reset, state_ff == ST_SEARCH || state_ff == ST_WAIT, len_ff != '0)

endmodule

`default_nettype wire

// ----- sim/tb_strict_lis_length.sv -----
`timescale 1ns / 1ps

module tb_strict_lis_length;

   // Cycles with no transaction on either channel before the run is abandoned.
   // Worst legitimate quiet spell: long receiver hold-off plus a deep
   // search plus a pause for the pipeline to drain.
   localparam int STILL_LIMIT = 4000;
   // receiver hold-off long enough to back the block up onto req_ch
   localparam int LONG_STALL  = 80;
   // final stretch of stimulus sent with no idling on either side
   localparam int QUIET_TAIL  = 60;
   // length of the long rising run
   localparam int DEEP_LEN    = 150;

   typedef struct packed {
      lis_pkg::value_type value;
      logic               last;
      logic               drain_first;   // hold back until every result is in
   } value_item_type;

   typedef struct packed {
      lis_pkg::length_type length;
      logic                final_res;
      logic                overflow;
   } length_result_type;

   logic clock;
   logic reset;

   lis_req_if req_ch ();
   lis_rsp_if rsp_ch ();

   strict_lis_length u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // stimulus still to send, and results still owed by the block
   value_item_type    value_q[$];
   length_result_type length_expect_q[$];

   // predictor state: smallest tail per subsequence length
   lis_pkg::value_type tail_min[lis_pkg::MAX_LEN];
   int                 run_len;
   logic               ovf_seen;

   int   mismatch_n;
   int   sent_n;
   int   got_n;
   int   gap_left;
   int   stall_left;
   bit   long_stall_done;
   bit   quiet;
   int   still_cycles;
   value_item_type    next_item;
   length_result_type want;

   // -------------------------------------------------------------------------
   // Predictor. Applies one value to the tail table and returns the result
   // transaction the block should produce for it. A value above the top tail
   // grows the table (or is dropped and flags overflow when full); a repeat
   // of the top changes nothing; anything else lowers the first tail that is
   // not below it. A linear scan finds that tail - slower than the block's
   // binary search but trivially right.
   // -------------------------------------------------------------------------
   function automatic length_result_type lis_advance(input lis_pkg::value_type v,
                                                     input logic fin);
      int                pos;
      length_result_type r;
      if (run_len == 0) begin
         tail_min[0] = v;
         run_len     = 1;
      end else if (v > tail_min[run_len-1]) begin
         if (run_len < lis_pkg::MAX_LEN) begin
            tail_min[run_len] = v;
            run_len++;
         end else begin
            ovf_seen = 1'b1;
         end
      end else if (v != tail_min[run_len-1]) begin
         pos = 0;
         while (tail_min[pos] < v) pos++;
         tail_min[pos] = v;
      end
      r.length    = lis_pkg::length_type'(run_len);
      r.final_res = fin;
      r.overflow  = ovf_seen;
      // sequence closed: length and overflow start afresh, tails just go stale
      if (fin) begin
         run_len  = 0;
         ovf_seen = 1'b0;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at result %0d: %s", got_n, what);
      mismatch_n++;
   endtask

   task automatic add_item(input lis_pkg::value_type v, input logic fin, input logic drain);
      value_item_type it;
      it.value       = v;
      it.last        = fin;
      it.drain_first = drain;
      value_q.push_back(it);
   endtask

   // Directed part: field extremes, append / repeat-of-top / replace, a lone
   // value that is also last, a falling run, and repeats below the top.
   task automatic add_directed();
      // most negative first: empty table always appends
      add_item(lis_pkg::value_type'(32'h8000_0000), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(32'h7fff_ffff), 1'b0, 1'b0);   // append at the top
      add_item(lis_pkg::value_type'(32'h7fff_ffff), 1'b0, 1'b0);   // equal to top
      add_item(lis_pkg::value_type'(0),             1'b0, 1'b0);   // replaces the top
      add_item(lis_pkg::value_type'(-1),            1'b0, 1'b0);   // lowers the top
      add_item(lis_pkg::value_type'(32'h8000_0000), 1'b0, 1'b0);   // equal to bottom
      add_item(lis_pkg::value_type'(5),             1'b1, 1'b0);   // append and close
      // single-value sequence
      add_item(lis_pkg::value_type'(-42),           1'b1, 1'b0);
      // strictly falling: length never passes one
      add_item(lis_pkg::value_type'(100), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(50),  1'b0, 1'b0);
      add_item(lis_pkg::value_type'(10),  1'b0, 1'b0);
      add_item(lis_pkg::value_type'(-10), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(-20), 1'b1, 1'b0);
      // repeats below the top must not count as growth
      add_item(lis_pkg::value_type'(1), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(2), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(3), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(2), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(2), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(3), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(4), 1'b1, 1'b0);
   endtask

   // Long rising run that builds a deep table. A repeat of the top and a
   // value near the bottom then exercise a long search.
   task automatic add_deep_run();
      longint acc;
      acc = -64'sd2000000000 + $urandom_range(0, 1000);
      for (int i = 0; i < DEEP_LEN; i++) begin
         acc += $urandom_range(1, 5000);
         add_item(lis_pkg::value_type'(acc), 1'b0, 1'b0);
      end
      add_item(lis_pkg::value_type'(acc), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(-64'sd1999998000), 1'b0, 1'b0);
      add_item(lis_pkg::value_type'(acc + 1), 1'b1, 1'b0);
   endtask

   // Random sequences, each closed by a last value. Styles: full-range noise,
   // a narrow band full of repeats, a rising drift with dips (grows deep
   // tables), and noise with repeated neighbours.
   task automatic add_random_sequences(input int target);
      int                 n;
      int                 style;
      int                 len;
      longint             acc;
      lis_pkg::value_type v;
      bit                 drained_mid;
      n           = 0;
      v           = '0;
      drained_mid = 1'b0;
      while (n < target) begin
         style = $urandom_range(0, 3);
         len   = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
         if (len > 40) style = 2;
         acc = longint'(lis_pkg::value_type'($urandom()));
         for (int i = 0; i < len; i++) begin
            case (style)
               0: v = lis_pkg::value_type'($urandom());
               1: v = lis_pkg::value_type'(int'($urandom_range(0, 16)) - 8);
               2: begin
                  acc = acc + $urandom_range(0, 250) - 50;
                  if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                  if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                  v = lis_pkg::value_type'(acc);
               end
               default: begin
                  if (i == 0 || $urandom_range(0, 3) != 0)
                     v = lis_pkg::value_type'($urandom());
               end
            endcase
            // drain the block at the start of the random part and once midway
            add_item(v, logic'(i == len - 1),
                     logic'(i == 0 && (n == 0 || (!drained_mid && n >= target / 2))));
            if (i == 0 && n >= target / 2) drained_mid = 1'b1;
            n++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Driver. On each accepted transaction the prediction is queued. Valid
   // holds while ready is low; otherwise the next value is offered, after an
   // optional gap. Gaps are switched off in every third window of 64
   // transactions and in the final stretch.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     = 0;
      end else begin
         quiet = (value_q.size() < QUIET_TAIL);
         if (req_ch.valid && req_ch.ready) begin
            length_expect_q.push_back(lis_advance(req_ch.value, req_ch.last));
            sent_n++;
            if (!quiet && ((sent_n / 64) % 3 != 2) && $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(1, 3);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // offer stands until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (value_q.size() != 0 &&
                      !(value_q[0].drain_first && length_expect_q.size() != 0)) begin
            next_item = value_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.value <= next_item.value;
            req_ch.last  <= next_item.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. Checks each accepted result field by field against the oldest
   // prediction. Ready drops in bursts, except in every third window of 50
   // results and in the final stretch; once, after 150 results, a LONG_STALL
   // hold-off fills the output reg and the done state so req_ch.ready falls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_n++;
            if (length_expect_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected transaction, length %0d",
                                       rsp_ch.length));
            end else begin
               want = length_expect_q.pop_front();
               if (rsp_ch.length !== want.length)
                  flag_mismatch($sformatf("length %0d, expected %0d",
                                          rsp_ch.length, want.length));
               if (rsp_ch.final_res !== want.final_res)
                  flag_mismatch($sformatf("final_res %b, expected %b",
                                          rsp_ch.final_res, want.final_res));
               if (rsp_ch.overflow !== want.overflow)
                  flag_mismatch($sformatf("overflow %b, expected %b",
                                          rsp_ch.overflow, want.overflow));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_stall_done && got_n >= 150) begin
            long_stall_done = 1'b1;
            stall_left      = LONG_STALL - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && ((got_n / 50) % 3 != 1) && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: any transaction on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         still_cycles <= 0;
      end else if (still_cycles >= STILL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         still_cycles <= still_cycles + 1;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.value    = '0;
      req_ch.last     = 1'b0;
      rsp_ch.ready    = 1'b0;
      run_len         = 0;
      ovf_seen        = 1'b0;
      mismatch_n      = 0;
      sent_n          = 0;
      got_n           = 0;
      still_cycles    = 0;
      long_stall_done = 1'b0;
      quiet           = 1'b0;

      add_directed();
      add_deep_run();
      add_random_sequences(500);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // everything sent and every prediction matched off
      while (value_q.size() != 0 || req_ch.valid || length_expect_q.size() != 0)
         @(posedge clock);
      // room for any stray transaction, beyond the worst search latency
      repeat (40) @(posedge clock);

      if (mismatch_n == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
